// File: rtl/cv3zp_pkg.sv
`timescale 1ns / 1ps

package cv3zp_pkg;

  localparam int MAX_SIZE    = 1024;
  localparam int ADDR_W      = $clog2(MAX_SIZE);
  localparam int SIZE_W      = 11;
  localparam int PIX_W       = 16;
  localparam int POS_W       = 10;
  localparam int VALUE_W     = 29;
  localparam int COEF_W      = 12;
  localparam int SEL_W       = 4;
  localparam int NUM_KERNELS = 11;
  localparam int TAPS        = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd8;

  // coefficients in units of 1/256, row-major
  localparam int KERNELS [NUM_KERNELS][TAPS] = '{
    '{0, 0, 0, 0, 256, 0, 0, 0, 0},
    '{0, -256, 0, -256, 1280, -256, 0, -256, 0},
    '{28, 28, 28, 28, 28, 28, 28, 28, 28},
    '{0, 0, 0, -256, 256, 0, 0, 0, 0},
    '{-512, -256, 0, -256, 256, 256, 0, 256, 512},
    '{0, 256, 0, 256, -1024, 256, 0, 256, 0},
    '{-256, 0, 256, -512, 0, 512, -256, 0, 256},
    '{0, -256, 0, -256, 1280, -256, 0, -256, 0},
    '{256, 256, 256, 256, -512, 256, -256, -256, -256},
    '{-256, 256, 256, -256, -512, 256, -256, 256, 256},
    '{15, 31, 15, 31, 64, 31, 15, 31, 15}
  };

endpackage

// File: rtl/conv3x3_zero_pad_stream.sv
`timescale 1ns / 1ps

// 3x3 convolution of a square image with zero padding, streamed in raster order.
// Input channel (in_valid/in_ready): one word per pixel, in_mode 0, row by row.
// After the last row send image_size drain words (in_mode 1); they produce the
// bottom row of results. Words of the wrong mode for the current phase are
// consumed and dropped.
// Output channel (out_valid/out_ready): one word per result, with its row and
// column; from the second row on, the last pixel of a row of two or more pixels produces two words.
// Configuration: cfg_we writes register cfg_index from cfg_wdata; index 0 picks
// the kernel, index 1 sets the side length and restarts the image at row 0.
// Write it only while the block is idle.
// A result word is registered in stage B, stage C and the output buffer after the pixel that completes it.
// Throughput: one pixel per cycle while the output buffer has room; an end-of-row
// pixel that gives two words fills both entries of the output buffer behind the single output port.
// Line stores are two single-port-write RAMs read at stage A into registers used at stage B.
// Reset: side length 8, identity kernel, position row 0 column 0, no clearing
// pass. A stalled receiver fills a two-word output buffer, then stalls the
// pipeline and drops in_ready; nothing is lost.

module conv3x3_zero_pad_stream (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_mode,
  input  logic [cv3zp_pkg::PIX_W-1:0]             in_pixel,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cv3zp_pkg::VALUE_W-1:0]    out_value,
  output logic [cv3zp_pkg::POS_W-1:0]             out_row,
  output logic [cv3zp_pkg::POS_W-1:0]             out_column,
  output logic                                    out_end_of_run,
  output logic                                    out_end_of_image,
  input  logic                                    cfg_we,
  input  logic [cv3zp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cv3zp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int AW = cv3zp_pkg::ADDR_W;
  localparam int SW = cv3zp_pkg::SIZE_W;
  localparam int PW = cv3zp_pkg::PIX_W;
  localparam int QW = cv3zp_pkg::POS_W;
  localparam int VW = cv3zp_pkg::VALUE_W;
  localparam int CW = cv3zp_pkg::COEF_W;

  // configuration and position
  logic [cv3zp_pkg::SEL_W-1:0] kern_r;
  logic [SW-1:0]               n_r;
  logic [AW-1:0]               col_r;
  logic [SW-1:0]               row_r;
  logic                        drain_r;
  logic [PW-1:0]               win_r [3][3];

  // stage B
  logic          b_valid_r, b_drain_r, b_r1_r, b_r2_r, b_first_r, b_last_col_r, b_last_row_r;
  logic [PW-1:0] b_pix_r;
  logic [AW-1:0] b_col_r;
  logic [QW-1:0] b_orow_r;
  logic          byp_r;
  logic [PW-1:0] fwd_up_r, fwd_mid_r, rd_up_r, rd_mid_r;

  // stage C
  logic                 c_valid_r, c_main_r, c_tail_r, c_last_row_r;
  logic [QW-1:0]        c_row_r, c_col_main_r, c_col_tail_r;
  logic signed [VW-1:0] main_p_r [9];
  logic signed [VW-1:0] tail_p_r [6];

  // output buffer
  logic [1:0]           ocnt_r;
  logic signed [VW-1:0] o0_value_r, o1_value_r;
  logic [QW-1:0]        o0_row_r, o1_row_r, o0_col_r, o1_col_r;
  logic                 o0_eor_r, o1_eor_r, o0_eoi_r, o1_eoi_r;

  logic [PW-1:0] upper_mem [cv3zp_pkg::MAX_SIZE];
  logic [PW-1:0] middle_mem [cv3zp_pkg::MAX_SIZE];

  logic          cfg_size_wr;
  logic [SW-1:0] size_nxt;
  logic [SW-1:0] n_m1;
  logic [AW-1:0] a_col;
  logic          a_last_col, a_take, byp_nxt;
  logic [SW-1:0] row_inc;
  logic          b_adv, b_wr;
  logic [PW-1:0] mid_eff, up_eff;
  logic [PW-1:0] win_nxt [3][3];
  logic signed [CW-1:0] coef [9];
  logic signed [VW-1:0] main_p [9];
  logic signed [VW-1:0] tail_p [6];
  logic [1:0]           c_k;
  logic                 c_adv, pop;
  logic signed [VW-1:0] sum_main, sum_tail;

  assign cfg_size_wr = cfg_we && (cfg_index == cv3zp_pkg::REG_IMAGE_SIZE);

  always_comb begin
    size_nxt = cfg_wdata[SW-1:0];
    if (size_nxt == '0) begin
      size_nxt = SW'(1);
    end else if (size_nxt > SW'(cv3zp_pkg::MAX_SIZE)) begin
      size_nxt = SW'(cv3zp_pkg::MAX_SIZE);
    end
  end

  // stage A: position bookkeeping and line store read
  assign n_m1       = n_r - SW'(1);
  assign a_col      = ({{(SW-AW){1'b0}}, col_r} >= n_r) ? '0 : col_r;
  assign a_last_col = ({{(SW-AW){1'b0}}, a_col} == n_m1);
  assign in_ready   = !b_valid_r || b_adv;
  assign a_take     = in_valid && in_ready && (in_mode == drain_r);
  assign row_inc    = row_r + SW'(1);
  assign byp_nxt    = a_take && b_wr && (b_col_r == a_col);

  // stage B: window update and products
  assign b_adv   = b_valid_r && (!c_valid_r || c_adv);
  assign b_wr    = b_adv && !b_drain_r;
  assign mid_eff = b_r1_r ? (byp_r ? fwd_mid_r : rd_mid_r) : '0;
  assign up_eff  = b_r2_r ? (byp_r ? fwd_up_r : rd_up_r) : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = b_first_r ? '0 : win_r[i][1];
      win_nxt[i][1] = b_first_r ? '0 : win_r[i][2];
    end
    win_nxt[0][2] = up_eff;
    win_nxt[1][2] = mid_eff;
    win_nxt[2][2] = b_pix_r;
  end

  always_comb begin
    for (int p = 0; p < 9; p++) begin
      coef[p] = CW'(cv3zp_pkg::KERNELS[kern_r][p]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        main_p[i*3+j] = VW'($signed({1'b0, win_nxt[i][j]})) * VW'(coef[i*3+j]);
      end
      tail_p[i*2]   = VW'($signed({1'b0, win_nxt[i][1]})) * VW'(coef[i*3]);
      tail_p[i*2+1] = VW'($signed({1'b0, win_nxt[i][2]})) * VW'(coef[i*3+1]);
    end
  end

  // stage C: sums
  assign c_k   = {1'b0, c_main_r} + {1'b0, c_tail_r};
  assign c_adv = c_valid_r && ((c_k == 2'd0) || (ocnt_r == 2'd0) ||
                               ((ocnt_r == 2'd1) && out_ready));
  assign pop   = (ocnt_r != 2'd0) && out_ready;

  always_comb begin
    sum_main = '0;
    sum_tail = '0;
    for (int p = 0; p < 9; p++) begin
      sum_main = sum_main + main_p_r[p];
    end
    for (int p = 0; p < 6; p++) begin
      sum_tail = sum_tail + tail_p_r[p];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r    <= '0;
      n_r       <= cv3zp_pkg::SIZE_RESET;
      col_r     <= '0;
      row_r     <= '0;
      drain_r   <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      ocnt_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_we && (cfg_index == cv3zp_pkg::REG_FILTER_SELECT)) begin
        kern_r <= (cfg_wdata[3:0] < 4'(cv3zp_pkg::NUM_KERNELS)) ? cfg_wdata[3:0] : '0;
      end
      if (cfg_size_wr) begin
        n_r     <= size_nxt;
        col_r   <= '0;
        row_r   <= '0;
        drain_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_r[i][j] <= '0;
          end
        end
      end else begin
        if (a_take) begin
          if (a_last_col) begin
            col_r <= '0;
            if (in_mode) begin
              row_r   <= '0;
              drain_r <= 1'b0;
            end else begin
              row_r <= row_inc;
              if (row_inc >= n_r) begin
                drain_r <= 1'b1;
              end
            end
          end else begin
            col_r <= a_col + AW'(1);
          end
        end
        if (b_adv) begin
          win_r <= win_nxt;
        end
      end
      if (a_take) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        c_valid_r <= 1'b1;
      end else if (c_adv) begin
        c_valid_r <= 1'b0;
      end
      if (c_adv && (c_k != 2'd0)) begin
        ocnt_r <= c_k;
      end else if (pop) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_take) begin
      b_drain_r    <= in_mode;
      b_pix_r      <= in_mode ? '0 : in_pixel;
      b_col_r      <= a_col;
      b_r1_r       <= (row_r != '0);
      b_r2_r       <= (row_r > SW'(1));
      b_first_r    <= (a_col == '0);
      b_last_col_r <= a_last_col;
      b_last_row_r <= (row_r == n_r);
      b_orow_r     <= QW'(row_r - SW'(1));
      byp_r        <= byp_nxt;
      fwd_up_r     <= mid_eff;
      fwd_mid_r    <= b_pix_r;
    end
    if (b_adv) begin
      c_main_r     <= b_r1_r && !b_first_r;
      c_tail_r     <= b_r1_r && b_last_col_r;
      c_last_row_r <= b_last_row_r;
      c_row_r      <= b_orow_r;
      c_col_main_r <= QW'(b_col_r - AW'(1));
      c_col_tail_r <= QW'(n_m1);
      main_p_r     <= main_p;
      tail_p_r     <= tail_p;
    end
    if (c_adv && (c_k != 2'd0)) begin
      o0_value_r <= c_main_r ? sum_main : sum_tail;
      o0_row_r   <= c_row_r;
      o0_col_r   <= c_main_r ? c_col_main_r : c_col_tail_r;
      o0_eor_r   <= c_main_r ? !c_tail_r : 1'b1;
      o0_eoi_r   <= c_main_r ? 1'b0 : c_last_row_r;
      o1_value_r <= sum_tail;
      o1_row_r   <= c_row_r;
      o1_col_r   <= c_col_tail_r;
      o1_eor_r   <= 1'b1;
      o1_eoi_r   <= c_last_row_r;
    end else if (pop) begin
      o0_value_r <= o1_value_r;
      o0_row_r   <= o1_row_r;
      o0_col_r   <= o1_col_r;
      o0_eor_r   <= o1_eor_r;
      o0_eoi_r   <= o1_eoi_r;
    end
  end

  // line stores: read at stage A, written when a pixel word (not a drain word) leaves stage B
  always_ff @(posedge clk) begin
    if (a_take) begin
      rd_up_r <= upper_mem[a_col];
    end
    if (b_wr) begin
      upper_mem[b_col_r] <= mid_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      rd_mid_r <= middle_mem[a_col];
    end
    if (b_wr) begin
      middle_mem[b_col_r] <= b_pix_r;
    end
  end

  assign out_valid        = (ocnt_r != 2'd0);
  assign out_value        = o0_value_r;
  assign out_row          = o0_row_r;
  assign out_column       = o0_col_r;
  assign out_end_of_run   = o0_eor_r;
  assign out_end_of_image = o0_eoi_r;

`ifndef SYNTHESIS
  a_stage_b_free: assert property (@(posedge clk) disable iff (!rst_n)
    (a_take && b_valid_r) |-> b_adv)
    else $error("stage B overwritten");

  a_bypass_size_one: assert property (@(posedge clk) disable iff (!rst_n)
    byp_nxt |-> (n_r == SW'(1)))
    else $error("line store bypass outside single column image");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({{(SW-AW){1'b0}}, col_r} < n_r))
    else $error("column counter out of range");

  a_pair_fills_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (c_adv && c_main_r && c_tail_r) |=> (ocnt_r == 2'd2))
    else $error("result pair not buffered");

  a_eoi_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_image) |-> out_end_of_run)
    else $error("end of image without end of run");
`endif

endmodule

// File: dv/tb_conv3x3_zero_pad_stream.sv
`timescale 1ns / 1ps

module tb_conv3x3_zero_pad_stream;

  localparam int          CLK_PERIOD    = 10;
  localparam int          MAX_SIDE      = cv3zp_pkg::MAX_SIZE;
  localparam int          VW            = cv3zp_pkg::VALUE_W;
  localparam int          PW            = cv3zp_pkg::POS_W;
  localparam int unsigned LIMIT         = 2_000_000;
  localparam int          DRAIN_GUARD   = 20_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          RANDOM_WORDS  = 730;
  localparam int unsigned STALL_PHASE   = 4;
  localparam int unsigned NO_REFILTER   = 32'hFFFF_FFFF;

  localparam bit MODE_PIXEL = 1'b0;
  localparam bit MODE_DRAIN = 1'b1;

  localparam logic [cv3zp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [cv3zp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // kernel taps in units of 1/256, row-major; entry 0 is the identity
  localparam int TAP_WEIGHTS [11][9] = '{
    '{0, 0, 0, 0, 256, 0, 0, 0, 0},
    '{0, -256, 0, -256, 1280, -256, 0, -256, 0},
    '{28, 28, 28, 28, 28, 28, 28, 28, 28},
    '{0, 0, 0, -256, 256, 0, 0, 0, 0},
    '{-512, -256, 0, -256, 256, 256, 0, 256, 512},
    '{0, 256, 0, 256, -1024, 256, 0, 256, 0},
    '{-256, 0, 256, -512, 0, 512, -256, 0, 256},
    '{0, -256, 0, -256, 1280, -256, 0, -256, 0},
    '{256, 256, 256, 256, -512, 256, -256, -256, -256},
    '{-256, 256, 256, -256, -512, 256, -256, 256, 256},
    '{15, 31, 15, 31, 64, 31, 15, 31, 15}
  };

  typedef logic [cv3zp_pkg::PIX_W-1:0] win_t [3][3];

  typedef struct packed {
    logic [VW-1:0] value;
    logic [PW-1:0] row;
    logic [PW-1:0] column;
    logic          end_of_run;
    logic          end_of_image;
  } conv_result_t;

  class conv_scoreboard;
    logic [3:0]   kernel_sel;
    logic [10:0]  side_reg;
    logic [15:0]  upper_line [MAX_SIDE];
    logic [15:0]  middle_line [MAX_SIDE];
    win_t         win;
    int unsigned  row_cnt;
    int unsigned  col_cnt;
    bit           draining;
    conv_result_t due_pixels [$];
    int unsigned  words_taken;
    int unsigned  words_dropped;
    int unsigned  pixels_matched;
    int unsigned  mismatches;
    int unsigned  images_done;
    bit [15:0]    sel_seen;

    function new();
      kernel_sel = 4'd0;
      side_reg   = cv3zp_pkg::SIZE_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      row_cnt  = 0;
      col_cnt  = 0;
      draining = 1'b0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function int unsigned side();
      int unsigned n;
      n = side_reg;
      if (n < 1) n = 1;
      if (n > MAX_SIDE) n = MAX_SIDE;
      return n;
    endfunction

    function void write_reg(input logic [cv3zp_pkg::CFG_IDX_W-1:0] idx,
                            input logic [cv3zp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cv3zp_pkg::REG_FILTER_SELECT: begin
          kernel_sel = data[3:0];
          sel_seen[data[3:0]] = 1'b1;
        end
        cv3zp_pkg::REG_IMAGE_SIZE: begin
          side_reg = data;
          restart();
        end
        default: ;
      endcase
    endfunction

    function logic [VW-1:0] window_sum(input win_t w);
      int unsigned k;
      longint      acc;
      k   = (kernel_sel <= 4'd10) ? kernel_sel : 0;
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          acc += longint'(w[i][j]) * TAP_WEIGHTS[k][i*3+j];
      return acc[VW-1:0];
    endfunction

    function void take_word(input bit mode, input logic [15:0] pix);
      int unsigned  n, c, r;
      logic [15:0]  up, mid, px;
      win_t         tail;
      conv_result_t res;
      n = side();
      c = col_cnt;
      r = row_cnt;
      words_taken++;
      if (mode != draining) begin
        words_dropped++;
        return;
      end
      px = mode ? 16'h0 : pix;
      if (c >= n) c = 0;
      up  = (r >= 2) ? upper_line[c] : 16'h0;
      mid = (r >= 1) ? middle_line[c] : 16'h0;
      if (c == 0) foreach (win[i, j]) win[i][j] = '0;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      if (!mode) begin
        upper_line[c]  = mid;
        middle_line[c] = px;
      end
      if (r >= 1) begin
        if (c >= 1) begin
          res.value        = window_sum(win);
          res.row          = PW'(r - 1);
          res.column       = PW'(c - 1);
          res.end_of_run   = (c != n - 1);
          res.end_of_image = 1'b0;
          due_pixels.push_back(res);
        end
        if (c == n - 1) begin
          for (int i = 0; i < 3; i++) begin
            tail[i][0] = win[i][1];
            tail[i][1] = win[i][2];
            tail[i][2] = '0;
          end
          res.value        = window_sum(tail);
          res.row          = PW'(r - 1);
          res.column       = PW'(n - 1);
          res.end_of_run   = 1'b1;
          res.end_of_image = ((r - 1) == (n - 1));
          due_pixels.push_back(res);
        end
      end
      if (c == n - 1) begin
        col_cnt = 0;
        if (mode) begin
          row_cnt  = 0;
          draining = 1'b0;
          images_done++;
        end else begin
          row_cnt = (r + 1) & 32'h7FF;
          if (row_cnt >= n) draining = 1'b1;
        end
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void report(input string what, input conv_result_t exp, input conv_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch (%s): exp value %0d row %0d col %0d eor %0b eoi %0b",
                 $time, what, $signed(exp.value), exp.row, exp.column, exp.end_of_run,
                 exp.end_of_image);
        $display("    got value %0d row %0d col %0d eor %0b eoi %0b",
                 $signed(got.value), got.row, got.column, got.end_of_run,
                 got.end_of_image);
      end
    endfunction

    function void match_pixel(input conv_result_t got);
      conv_result_t exp;
      if (due_pixels.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      exp = due_pixels.pop_front();
      if (got.value !== exp.value || got.row !== exp.row || got.column !== exp.column ||
          got.end_of_run !== exp.end_of_run || got.end_of_image !== exp.end_of_image)
        report("field", exp, got);
      else
        pixels_matched++;
    endfunction

    function void flag_leftovers();
      while (due_pixels.size() != 0) report("missing word", due_pixels.pop_front(), '0);
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 in_mode = 1'b0;
  logic [cv3zp_pkg::PIX_W-1:0]          in_pixel = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [VW-1:0]                 out_value;
  logic [PW-1:0]                        out_row;
  logic [PW-1:0]                        out_column;
  logic                                 out_end_of_run;
  logic                                 out_end_of_image;
  logic                                 cfg_we = 1'b0;
  logic [cv3zp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [cv3zp_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

  conv_scoreboard sb = new();
  bit             steady_send = 1'b0;
  bit             stall_request = 1'b0;
  int unsigned    stalls_done = 0;
  int unsigned    noise_pct = 4;
  int unsigned    cycle_count = 0;

  conv3x3_zero_pad_stream DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_image (out_end_of_image),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[conv3x3_zero_pad_stream] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    conv_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.value        = out_value;
      got.row          = out_row;
      got.column       = out_column;
      got.end_of_run   = out_end_of_run;
      got.end_of_image = out_end_of_image;
      sb.match_pixel(got);
    end
  end

  // receiver: random ready runs, plus one long hold-off on request
  initial begin
    int unsigned ready_run;
    int unsigned pick;
    bit          ready_lvl;
    ready_run = 0;
    ready_lvl = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stalls_done++;
        ready_run = 0;
      end
      if (ready_run == 0) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          ready_lvl = 1'b1;
          ready_run = $urandom_range(20, 1);
        end else if (pick < 65) begin
          ready_lvl = 1'b1;
          ready_run = $urandom_range(300, 100);
        end else if (pick < 95) begin
          ready_lvl = 1'b0;
          ready_run = $urandom_range(3, 1);
        end else begin
          ready_lvl = 1'b0;
          ready_run = $urandom_range(60, 20);
        end
      end
      out_ready <= ready_lvl;
      ready_run--;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [15:0] rand_pixel();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return 16'h0000;
    if (p < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic push_word(input bit mode, input logic [15:0] pix);
    int unsigned gap;
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    sb.take_word(mode, pix);
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every expected word is out and the pipeline is quiet
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.due_pixels.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    sb.flag_leftovers();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [cv3zp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cv3zp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are don't-care for the selector
  task automatic set_filter(input logic [3:0] sel);
    logic [cv3zp_pkg::CFG_DATA_W-1:0] d;
    d      = cv3zp_pkg::CFG_DATA_W'($urandom);
    d[3:0] = sel;
    write_cfg(cv3zp_pkg::REG_FILTER_SELECT, d);
  endtask

  task automatic send_image(input int unsigned n, input int unsigned cut,
                            input int unsigned refilter_at);
    int unsigned total;
    total = n * n + n;
    for (int unsigned k = 0; k < total && k < cut; k++) begin
      if (k == refilter_at) begin
        settle();
        set_filter(4'($urandom_range(15)));
      end
      if ($urandom_range(99) < noise_pct)
        push_word((k < n * n) ? MODE_DRAIN : MODE_PIXEL, rand_pixel());
      push_word((k < n * n) ? MODE_PIXEL : MODE_DRAIN, rand_pixel());
    end
  endtask

  initial begin
    int unsigned n, prev_n, total, cut, refilter_at, pick, goal, phase;
    bit          need_size;
    logic [cv3zp_pkg::CFG_DATA_W-1:0] size_data;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unused register indexes must be harmless
    write_cfg(REG_SPARE_2, 11'h7FF);
    write_cfg(REG_SPARE_3, 11'h555);

    // 1x1 image, wrong-mode words around the drain
    set_filter(4'd1);
    write_cfg(cv3zp_pkg::REG_IMAGE_SIZE, 11'd1);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'h1234);
    push_word(MODE_DRAIN, 16'hFFFF);
    push_word(MODE_DRAIN, 16'h0000);
    settle();

    // size 0 behaves as 1, selector above 10 is identity
    set_filter(4'd12);
    write_cfg(cv3zp_pkg::REG_IMAGE_SIZE, 11'd0);
    push_word(MODE_PIXEL, 16'h8001);
    push_word(MODE_DRAIN, 16'hFFFF);
    settle();

    // 2x2 with negative taps, stray drain word mid-image
    set_filter(4'd8);
    write_cfg(cv3zp_pkg::REG_IMAGE_SIZE, 11'd2);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_DRAIN, 16'hABCD);
    push_word(MODE_PIXEL, 16'h0000);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_DRAIN, 16'h0000);
    push_word(MODE_DRAIN, 16'h0000);

    // next image back to back, kernel swapped between rows
    settle();
    set_filter(4'd15);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'h0001);
    settle();
    set_filter(4'd10);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_DRAIN, 16'h5555);
    push_word(MODE_DRAIN, 16'hAAAA);

    goal      = sb.words_taken + RANDOM_WORDS;
    phase     = 0;
    prev_n    = 2;
    need_size = 1'b0;
    while (sb.words_taken < goal || phase <= STALL_PHASE) begin
      settle();
      pick = $urandom_range(99);
      if (phase == STALL_PHASE) n = $urandom_range(10, 6);
      else if (pick < 25)   n = prev_n;
      else if (pick < 80)   n = $urandom_range(8, 1);
      else if (pick < 97)   n = $urandom_range(24, 9);
      else                  n = $urandom_range(40, 25);
      if (need_size || n != prev_n || $urandom_range(99) < 20) begin
        size_data = cv3zp_pkg::CFG_DATA_W'(n);
        if (n == 1 && $urandom_range(1)) size_data = '0;
        write_cfg(cv3zp_pkg::REG_IMAGE_SIZE, size_data);
      end
      if ($urandom_range(99) < 60) set_filter(4'($urandom_range(15)));
      total       = n * n + n;
      cut         = ($urandom_range(99) < 10) ? $urandom_range(total - 1) : total;
      need_size   = (cut < total);
      refilter_at = ($urandom_range(99) < 15 && total > 1) ?
                    $urandom_range(total - 1, 1) : NO_REFILTER;
      steady_send = (phase == STALL_PHASE) || ($urandom_range(99) < 20);
      if (phase == STALL_PHASE) stall_request = 1'b1;
      send_image(n, cut, refilter_at);
      steady_send = 1'b0;
      prev_n      = n;
      phase++;
    end
    settle();

    $display("covered %0d words (%0d out of phase), %0d results checked, %0d full images",
             sb.words_taken, sb.words_dropped, sb.pixels_matched, sb.images_done);
    $display("sides 0 to 40, %0d of 16 selector codes, %0d long receiver hold(s)",
             $countones(sb.sel_seen), stalls_done);
    if (sb.mismatches == 0) begin
      $display("[conv3x3_zero_pad_stream] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[conv3x3_zero_pad_stream] ERROR");
    end
    $finish;
  end

endmodule
